// ===== hw/rtl/sdsh_pkg.sv =====
// sdsh_pkg: types and constants for the sd spi host sequencer
// no dependencies
`default_nettype none
package sdsh_pkg;

    localparam int unsigned BLOCK_BYTES = 512;

    typedef enum logic [2:0] {
        C_INIT  = 3'd0,
        C_READ  = 3'd1,
        C_WRITE = 3'd2,
        C_XCHG  = 3'd3,
        C_WBYTE = 3'd4,
        C_TICK  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        K_SEND = 2'd0,
        K_RDAT = 2'd1,
        K_NEED = 2'd2,
        K_DONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ERR  = 2'd1,
        ST_NRDY = 2'd2,
        ST_PAR  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_INIT_TO   = 3'd0,
        REG_LEGACY_TO = 3'd1,
        REG_READY_TO  = 3'd2,
        REG_TOKEN_TO  = 3'd3,
        REG_POLLS     = 3'd4
    } t_reg;

    typedef enum logic [4:0] {
        P_IDLE, P_C_DESEL, P_C_RDY, P_C_FRAME, P_C_SKIP, P_C_RESP, P_WAIT,
        P_DESEL_DONE, P_I_DUMMY, P_I_OCR8, P_I_OCR58, P_I_DESEL1, P_I_DESEL2,
        P_I_FAST, P_R_TOK, P_R_DATA, P_R_CRC, P_W_TOK, P_W_NEED, P_W_DATA,
        P_W_CRC, P_W_RESP, P_W_STOP
    } t_phase;

    localparam logic [7:0] OP_0   = 8'h40;
    localparam logic [7:0] OP_1   = 8'h41;
    localparam logic [7:0] OP_8   = 8'h48;
    localparam logic [7:0] OP_12  = 8'h4C;
    localparam logic [7:0] OP_16  = 8'h50;
    localparam logic [7:0] OP_17  = 8'h51;
    localparam logic [7:0] OP_18  = 8'h52;
    localparam logic [7:0] OP_23  = 8'h57;
    localparam logic [7:0] OP_24  = 8'h58;
    localparam logic [7:0] OP_25  = 8'h59;
    localparam logic [7:0] OP_55  = 8'h77;
    localparam logic [7:0] OP_58  = 8'h7A;
    localparam logic [7:0] OP_A41 = 8'hE9;

    localparam logic [3:0] TY_MMC = 4'd1;
    localparam logic [3:0] TY_SD1 = 4'd2;
    localparam logic [3:0] TY_SD2 = 4'd4;
    localparam logic [3:0] TY_BLK = 4'd8;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] sector;
        logic [15:0] block_count;
        logic [7:0]  miso_byte;
        logic [7:0]  write_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       chip_select;
        logic       fast_clock;
        logic [1:0] status;
        logic [3:0] card_kind;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } t_cfg;

endpackage
`default_nettype wire

// ===== hw/rtl/sdsh_if.sv =====
// sdsh_if: valid/ready channel interfaces for items and configuration
// depends on sdsh_pkg
`default_nettype none
interface sdsh_in_if;
    logic           valid;
    logic           ready;
    sdsh_pkg::t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sdsh_out_if;
    logic           valid;
    logic           ready;
    sdsh_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sdsh_cfg_if;
    logic           valid;
    logic           ready;
    sdsh_pkg::t_cfg payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sdsh_outq.sv =====
// sdsh_outq: small result queue, up to two items pushed per cycle
// depends on sdsh_pkg
`default_nettype none
module sdsh_outq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [1:0]      i_push_n,
    input  wire sdsh_pkg::t_out  i_item0,
    input  wire sdsh_pkg::t_out  i_item1,
    output logic                 o_room,
    output logic                 o_valid,
    output sdsh_pkg::t_out       o_item,
    input  wire logic            i_pop
);
    sdsh_pkg::t_out r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_mem[r_rp];
    assign pop     = i_pop && o_valid;
    // two free slots are needed for the worst case item
    assign o_room  = (r_cnt <= 3'd2);
    assign n_cnt   = r_cnt + {1'b0, i_push_n} - {2'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_push_n;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) r_mem[r_wp] <= i_item0;
        if (i_push_n == 2'd2) r_mem[r_wp + 2'd1] <= i_item1;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sd_spi_host_sequencer_top.sv =====
// sd_spi_host_sequencer_top: sd card spi mode init, read and write sequencer
// depends on sdsh_pkg, sdsh_if, sdsh_outq
//
// channel  | dir | content
// i_in     | in  | cmd, sector, block_count, miso_byte, write_byte
// o_out    | out | kind, byte_value, chip_select, fast_clock, status, card_kind, last
// i_cfg    | in  | register index, 16-bit data
//
// one item per cycle while input ready is high: the next phase and byte are
// worked out in one step from the registered state, results go to a four-entry queue
// input ready drops only while the queue has fewer than two free slots
// synchronous active-low reset returns to idle, uninitialised, default limits
`default_nettype none
module sd_spi_host_sequencer_top #(
    parameter int unsigned DUMMY_BYTES = 10
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sdsh_in_if.sink    i_in,
    sdsh_out_if.source o_out,
    sdsh_cfg_if.sink   i_cfg
);
    typedef enum logic [4:0] {
        R_NONE, R_CMD0, R_CMD8, R_A41, R_C58, R_V1, R_V1R, R_V1C16, R_C16F,
        R_RD, R_C12, R_W24, R_W55, R_W23, R_W25, R_WRDY, R_WBLK, R_WSTOP
    } t_ret;

    logic [15:0] r_init_to, r_legacy_to, r_ready_to, r_token_to;
    logic [7:0]  r_polls;

    sdsh_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_card, n_card, r_wty, n_wty;
    logic        r_noinit, n_noinit, r_cs, n_cs, r_fast, n_fast;
    logic [15:0] r_ms, n_ms, r_rdy, n_rdy;
    logic [7:0]  r_poll, n_poll;
    logic [9:0]  r_bi, n_bi;
    logic [15:0] r_left, n_left;
    logic [31:0] r_addr, n_addr;
    logic [47:0] r_frame, n_frame;
    logic [31:0] r_ocr, n_ocr, r_parg, n_parg;
    t_ret        r_cret, n_cret, r_wret, n_wret;
    logic [7:0]  r_resp, n_resp;
    logic        r_rdyok, n_rdyok, r_apend, n_apend, r_multi, n_multi;
    logic [7:0]  r_pcmd, n_pcmd;
    logic [1:0]  r_fst, n_fst;

    logic [1:0]      npush;
    sdsh_pkg::t_out  item0, item1;
    logic            room, acc;
    sdsh_pkg::t_in   d;

    assign d     = i_in.payload;
    assign acc   = i_in.valid && i_in.ready;
    assign i_in.ready  = room;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_to   <= 16'd3000;
            r_legacy_to <= 16'd1000;
            r_ready_to  <= 16'd500;
            r_token_to  <= 16'd500;
            r_polls     <= 8'd100;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                sdsh_pkg::REG_INIT_TO:   r_init_to   <= i_cfg.payload.data;
                sdsh_pkg::REG_LEGACY_TO: r_legacy_to <= i_cfg.payload.data;
                sdsh_pkg::REG_READY_TO:  r_ready_to  <= i_cfg.payload.data;
                sdsh_pkg::REG_TOKEN_TO:  r_token_to  <= i_cfg.payload.data;
                sdsh_pkg::REG_POLLS:     r_polls     <= i_cfg.payload.data[7:0];
                default: ;
            endcase
        end
    end

    function automatic logic [47:0] frame_of(input logic [7:0] op, input logic [31:0] arg);
        logic [7:0] crc;
        crc = (op == sdsh_pkg::OP_0) ? 8'h95 : (op == sdsh_pkg::OP_8) ? 8'h87 : 8'h01;
        return {op, arg, crc};
    endfunction

    function automatic logic [7:0] fbyte(input logic [47:0] f, input logic [9:0] k);
        logic [7:0] b;
        case (k)
            10'd0: b = f[47:40];
            10'd1: b = f[39:32];
            10'd2: b = f[31:24];
            10'd3: b = f[23:16];
            10'd4: b = f[15:8];
            10'd5: b = f[7:0];
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

    // the step is written as a sequence of blocking updates on n_ copies
    always_comb begin
        logic        emit_s, emit_d, emit_n, emit_r;
        logic [7:0]  sb, rb;
        logic [1:0]  dst;
        logic        rlast, go_cont, go_cmd, go_wait, go_ie, go_dd;
        t_ret        ck, cmd_ret, wret_v;
        logic [7:0]  cop, r8;
        logic [31:0] carg;
        logic [1:0]  dd_st;
        logic [15:0] lm1;
        logic [31:0] socr;

        n_phase = r_phase; n_card = r_card; n_wty = r_wty; n_noinit = r_noinit;
        n_cs = r_cs; n_fast = r_fast; n_ms = r_ms; n_rdy = r_rdy; n_poll = r_poll;
        n_bi = r_bi; n_left = r_left; n_addr = r_addr; n_frame = r_frame;
        n_ocr = r_ocr; n_parg = r_parg; n_cret = r_cret; n_wret = r_wret;
        n_resp = r_resp; n_rdyok = r_rdyok; n_apend = r_apend; n_multi = r_multi;
        n_pcmd = r_pcmd; n_fst = r_fst;
        emit_s = 1'b0; emit_d = 1'b0; emit_n = 1'b0; emit_r = 1'b0;
        sb = 8'hFF; rb = 8'h00; dst = sdsh_pkg::ST_OK; rlast = 1'b0;
        go_cont = 1'b0; go_cmd = 1'b0; go_wait = 1'b0; go_ie = 1'b0; go_dd = 1'b0;
        ck = R_NONE; cmd_ret = R_NONE; wret_v = R_NONE; cop = 8'h00; carg = '0;
        dd_st = sdsh_pkg::ST_OK; lm1 = r_left - 16'd1; socr = '0;
        r8 = d.miso_byte;

        if (acc) begin
            case (d.cmd)
                sdsh_pkg::C_TICK: begin
                    if (r_ms != 16'hFFFF) n_ms = r_ms + 16'd1;
                    if (r_rdy != 16'hFFFF) n_rdy = r_rdy + 16'd1;
                end
                sdsh_pkg::C_INIT: begin
                    if (r_phase == sdsh_pkg::P_IDLE) begin
                        n_fast = 1'b0; n_cs = 1'b0; n_bi = '0;
                        n_phase = sdsh_pkg::P_I_DUMMY; emit_s = 1'b1;
                    end
                end
                sdsh_pkg::C_READ, sdsh_pkg::C_WRITE: begin
                    if (r_phase == sdsh_pkg::P_IDLE) begin
                        if (d.block_count == 16'd0) begin
                            emit_d = 1'b1; dst = sdsh_pkg::ST_PAR;
                        end else if (r_noinit) begin
                            emit_d = 1'b1; dst = sdsh_pkg::ST_NRDY;
                        end else begin
                            n_addr = r_card[3] ? d.sector : {d.sector[22:0], 9'd0};
                            n_left = d.block_count;
                            n_multi = (d.block_count != 16'd1);
                            go_cmd = 1'b1; carg = n_addr;
                            if (d.cmd == sdsh_pkg::C_READ) begin
                                cop = n_multi ? sdsh_pkg::OP_18 : sdsh_pkg::OP_17;
                                cmd_ret = R_RD;
                            end else if (!n_multi) begin
                                cop = sdsh_pkg::OP_24; cmd_ret = R_W24;
                            end else if ((r_card & (sdsh_pkg::TY_SD1 | sdsh_pkg::TY_SD2)) != 0) begin
                                cop = sdsh_pkg::OP_55; carg = '0; cmd_ret = R_W55;
                            end else begin
                                cop = sdsh_pkg::OP_23; carg = {16'd0, d.block_count};
                                cmd_ret = R_W23;
                            end
                        end
                    end
                end
                sdsh_pkg::C_WBYTE: begin
                    if (r_phase == sdsh_pkg::P_W_NEED) begin
                        n_phase = sdsh_pkg::P_W_DATA; emit_s = 1'b1; sb = d.write_byte;
                    end
                end
                sdsh_pkg::C_XCHG: begin
                    unique case (r_phase)
                        sdsh_pkg::P_IDLE, sdsh_pkg::P_W_NEED: ;
                        sdsh_pkg::P_C_DESEL: begin
                            n_cs = 1'b1; n_bi = '0;
                            if (r_frame[47:40] == sdsh_pkg::OP_0) begin
                                n_phase = sdsh_pkg::P_C_FRAME; emit_s = 1'b1;
                                sb = r_frame[47:40];
                            end else begin
                                n_rdy = '0; n_phase = sdsh_pkg::P_C_RDY; emit_s = 1'b1;
                            end
                        end
                        sdsh_pkg::P_C_RDY: begin
                            if (r8 == 8'hFF) begin
                                n_bi = '0; n_phase = sdsh_pkg::P_C_FRAME; emit_s = 1'b1;
                                sb = r_frame[47:40];
                            end else if (r_rdy >= r_ready_to) begin
                                n_apend = 1'b0; n_resp = 8'hFF; go_cont = 1'b1; ck = r_cret;
                            end else emit_s = 1'b1;
                        end
                        sdsh_pkg::P_C_FRAME: begin
                            n_bi = r_bi + 10'd1;
                            emit_s = 1'b1;
                            if (n_bi < 10'd6) sb = fbyte(r_frame, n_bi);
                            else if (r_frame[47:40] == sdsh_pkg::OP_12)
                                n_phase = sdsh_pkg::P_C_SKIP;
                            else begin
                                n_poll = r_polls; n_phase = sdsh_pkg::P_C_RESP;
                            end
                        end
                        sdsh_pkg::P_C_SKIP: begin
                            n_poll = r_polls; n_phase = sdsh_pkg::P_C_RESP; emit_s = 1'b1;
                        end
                        sdsh_pkg::P_C_RESP: begin
                            n_poll = r_poll - 8'd1;
                            if (r8[7] && n_poll != 8'd0) emit_s = 1'b1;
                            else begin
                                n_resp = r8;
                                if (r_apend) begin
                                    n_apend = 1'b0;
                                    if (r8 > 8'd1) begin
                                        go_cont = 1'b1; ck = r_cret;
                                    end else begin
                                        n_frame = frame_of(r_pcmd, r_parg);
                                        n_cs = 1'b0; n_phase = sdsh_pkg::P_C_DESEL;
                                        emit_s = 1'b1;
                                    end
                                end else begin
                                    go_cont = 1'b1; ck = r_cret;
                                end
                            end
                        end
                        sdsh_pkg::P_WAIT: begin
                            if (r8 == 8'hFF) begin
                                n_rdyok = 1'b1; go_cont = 1'b1; ck = r_wret;
                            end else if (r_rdy >= r_ready_to) begin
                                n_rdyok = 1'b0; go_cont = 1'b1; ck = r_wret;
                            end else emit_s = 1'b1;
                        end
                        sdsh_pkg::P_DESEL_DONE: begin
                            emit_d = 1'b1; dst = r_fst;
                        end
                        sdsh_pkg::P_I_DUMMY: begin
                            n_bi = r_bi + 10'd1;
                            if (n_bi <= 10'(DUMMY_BYTES)) emit_s = 1'b1;
                            else begin
                                n_wty = '0; go_cmd = 1'b1; cop = sdsh_pkg::OP_0;
                                cmd_ret = R_CMD0;
                            end
                        end
                        sdsh_pkg::P_I_OCR8, sdsh_pkg::P_I_OCR58: begin
                            socr = {r_ocr[23:0], r8};
                            n_ocr = socr;
                            n_bi = r_bi + 10'd1;
                            if (n_bi < 10'd4) emit_s = 1'b1;
                            else if (r_phase == sdsh_pkg::P_I_OCR8) begin
                                if (socr[15:0] == 16'h01AA) begin
                                    if (r_ms < r_init_to) begin
                                        go_cmd = 1'b1; cop = sdsh_pkg::OP_A41;
                                        carg = 32'h4000_0000; cmd_ret = R_A41;
                                    end else go_ie = 1'b1;
                                end else go_ie = 1'b1;
                            end else begin
                                n_wty = socr[30] ? (sdsh_pkg::TY_SD2 | sdsh_pkg::TY_BLK)
                                                 : sdsh_pkg::TY_SD2;
                                go_ie = 1'b1;
                            end
                        end
                        sdsh_pkg::P_I_DESEL1: begin
                            if (r_wty != 0) begin
                                go_cmd = 1'b1; cop = sdsh_pkg::OP_16;
                                carg = 32'(sdsh_pkg::BLOCK_BYTES); cmd_ret = R_C16F;
                            end else begin
                                n_noinit = 1'b1; emit_d = 1'b1; dst = sdsh_pkg::ST_ERR;
                            end
                        end
                        sdsh_pkg::P_I_DESEL2: begin
                            if (r_wty == 0) begin
                                n_noinit = 1'b1; emit_d = 1'b1; dst = sdsh_pkg::ST_ERR;
                            end else begin
                                n_noinit = 1'b0; n_fast = 1'b1;
                                n_phase = sdsh_pkg::P_I_FAST; emit_s = 1'b1;
                            end
                        end
                        sdsh_pkg::P_I_FAST: begin
                            emit_d = 1'b1; dst = sdsh_pkg::ST_OK;
                        end
                        sdsh_pkg::P_R_TOK: begin
                            if (r8 == 8'hFE) begin
                                n_bi = '0; n_phase = sdsh_pkg::P_R_DATA; emit_s = 1'b1;
                            end else if (r_ms >= r_token_to) begin
                                go_dd = 1'b1; dd_st = sdsh_pkg::ST_ERR;
                            end else emit_s = 1'b1;
                        end
                        sdsh_pkg::P_R_DATA: begin
                            rlast = (r_bi >= 10'(sdsh_pkg::BLOCK_BYTES - 1));
                            emit_r = 1'b1; rb = r8;
                            if (rlast) begin
                                n_bi = '0; n_phase = sdsh_pkg::P_R_CRC;
                            end else n_bi = r_bi + 10'd1;
                        end
                        sdsh_pkg::P_R_CRC: begin
                            n_bi = r_bi + 10'd1;
                            if (n_bi < 10'd2) emit_s = 1'b1;
                            else if (!r_multi) begin
                                go_dd = 1'b1; dd_st = sdsh_pkg::ST_OK;
                            end else begin
                                n_left = lm1;
                                if (lm1 != 16'd0) begin
                                    n_ms = '0; n_phase = sdsh_pkg::P_R_TOK; emit_s = 1'b1;
                                end else begin
                                    go_cmd = 1'b1; cop = sdsh_pkg::OP_12; cmd_ret = R_C12;
                                end
                            end
                        end
                        sdsh_pkg::P_W_TOK: begin
                            n_bi = '0; n_phase = sdsh_pkg::P_W_NEED; emit_n = 1'b1;
                        end
                        sdsh_pkg::P_W_DATA: begin
                            n_bi = r_bi + 10'd1;
                            if ({1'b0, n_bi} < 11'(sdsh_pkg::BLOCK_BYTES) && n_bi != 10'd0) begin
                                n_phase = sdsh_pkg::P_W_NEED; emit_n = 1'b1;
                            end else begin
                                n_bi = '0; n_phase = sdsh_pkg::P_W_CRC; emit_s = 1'b1;
                            end
                        end
                        sdsh_pkg::P_W_CRC: begin
                            n_bi = r_bi + 10'd1;
                            if (n_bi >= 10'd2) n_phase = sdsh_pkg::P_W_RESP;
                            emit_s = 1'b1;
                        end
                        sdsh_pkg::P_W_RESP: begin
                            if (r8[4:0] != 5'h05) begin
                                go_dd = 1'b1; dd_st = sdsh_pkg::ST_ERR;
                            end else begin
                                go_wait = 1'b1; wret_v = R_WBLK;
                            end
                        end
                        sdsh_pkg::P_W_STOP: begin
                            go_wait = 1'b1; wret_v = R_WSTOP;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // continuation after a command or ready wait
        if (go_cont) begin
            case (ck)
                R_CMD0: begin
                    if (n_resp == 8'd1) begin
                        n_ms = '0; go_cmd = 1'b1; cop = sdsh_pkg::OP_8;
                        carg = 32'h1AA; cmd_ret = R_CMD8;
                    end else go_ie = 1'b1;
                end
                R_CMD8: begin
                    if (n_resp == 8'd1) begin
                        n_ocr = '0; n_bi = '0; n_phase = sdsh_pkg::P_I_OCR8; emit_s = 1'b1;
                    end else begin
                        go_cmd = 1'b1; cop = sdsh_pkg::OP_A41; cmd_ret = R_V1;
                    end
                end
                R_A41: begin
                    go_cmd = (r_ms < r_init_to);
                    go_ie = !go_cmd;
                    if (n_resp != 8'd0) begin
                        cop = sdsh_pkg::OP_A41; carg = 32'h4000_0000; cmd_ret = R_A41;
                    end else begin
                        cop = sdsh_pkg::OP_58; cmd_ret = R_C58;
                    end
                end
                R_C58: begin
                    if (n_resp == 8'd0) begin
                        n_ocr = '0; n_bi = '0; n_phase = sdsh_pkg::P_I_OCR58; emit_s = 1'b1;
                    end else go_ie = 1'b1;
                end
                R_V1, R_V1R: begin
                    if (ck == R_V1)
                        n_wty = (n_resp <= 8'd1) ? sdsh_pkg::TY_SD1 : sdsh_pkg::TY_MMC;
                    go_cmd = 1'b1;
                    if (ck == R_V1R && n_resp == 8'd0) begin
                        cop = sdsh_pkg::OP_16; carg = 32'(sdsh_pkg::BLOCK_BYTES);
                        cmd_ret = R_V1C16;
                    end else if (r_ms < r_legacy_to) begin
                        cop = (n_wty == sdsh_pkg::TY_SD1) ? sdsh_pkg::OP_A41 : sdsh_pkg::OP_1;
                        cmd_ret = R_V1R;
                    end else begin
                        cop = sdsh_pkg::OP_16; carg = 32'(sdsh_pkg::BLOCK_BYTES);
                        cmd_ret = R_V1C16;
                    end
                end
                R_V1C16: begin
                    if (r_ms >= r_legacy_to || n_resp != 8'd0) n_wty = '0;
                    go_ie = 1'b1;
                end
                R_C16F: begin
                    if (n_resp != 8'd0) n_wty = '0;
                    n_cs = 1'b0; n_phase = sdsh_pkg::P_I_DESEL2; emit_s = 1'b1;
                end
                R_RD: begin
                    if (n_resp == 8'd0) begin
                        n_ms = '0; n_phase = sdsh_pkg::P_R_TOK; emit_s = 1'b1;
                    end else begin
                        go_dd = 1'b1; dd_st = sdsh_pkg::ST_ERR;
                    end
                end
                R_C12: begin
                    go_dd = 1'b1; dd_st = sdsh_pkg::ST_OK;
                end
                R_W55: begin
                    go_cmd = 1'b1; cop = sdsh_pkg::OP_23; carg = {16'd0, r_left};
                    cmd_ret = R_W23;
                end
                R_W23: begin
                    go_cmd = 1'b1; cop = sdsh_pkg::OP_25; carg = r_addr; cmd_ret = R_W25;
                end
                R_W24, R_W25: begin
                    if (n_resp == 8'd0) begin
                        go_wait = 1'b1; wret_v = R_WRDY;
                    end else begin
                        go_dd = 1'b1; dd_st = sdsh_pkg::ST_ERR;
                    end
                end
                R_WRDY: begin
                    if (!n_rdyok) begin
                        go_dd = 1'b1; dd_st = sdsh_pkg::ST_ERR;
                    end else begin
                        n_phase = sdsh_pkg::P_W_TOK; emit_s = 1'b1;
                        sb = r_multi ? 8'hFC : 8'hFE;
                    end
                end
                R_WBLK: begin
                    if (!r_multi) begin
                        go_dd = 1'b1; dd_st = n_rdyok ? sdsh_pkg::ST_OK : sdsh_pkg::ST_ERR;
                    end else if (!n_rdyok) begin
                        n_phase = sdsh_pkg::P_W_STOP; emit_s = 1'b1; sb = 8'hFD;
                    end else begin
                        n_left = lm1; emit_s = 1'b1;
                        if (lm1 != 16'd0) begin
                            n_phase = sdsh_pkg::P_W_TOK; sb = 8'hFC;
                        end else begin
                            n_phase = sdsh_pkg::P_W_STOP; sb = 8'hFD;
                        end
                    end
                end
                R_WSTOP: begin
                    go_dd = 1'b1;
                    dd_st = (!n_rdyok || r_left != 16'd0) ? sdsh_pkg::ST_ERR : sdsh_pkg::ST_OK;
                end
                default: begin
                    emit_d = 1'b1; dst = sdsh_pkg::ST_ERR;
                end
            endcase
        end

        if (go_cmd) begin
            n_cret = cmd_ret;
            if (cop[7]) begin
                n_apend = 1'b1; n_pcmd = {1'b0, cop[6:0]}; n_parg = carg;
                n_frame = frame_of(sdsh_pkg::OP_55, '0);
            end else begin
                n_apend = 1'b0; n_frame = frame_of(cop, carg);
            end
            n_cs = 1'b0; n_phase = sdsh_pkg::P_C_DESEL; emit_s = 1'b1;
        end
        if (go_wait) begin
            n_wret = wret_v; n_rdy = '0; n_phase = sdsh_pkg::P_WAIT; emit_s = 1'b1;
        end
        if (go_ie) begin
            n_card = n_wty; n_cs = 1'b0; n_phase = sdsh_pkg::P_I_DESEL1; emit_s = 1'b1;
        end
        if (go_dd) begin
            n_fst = dd_st; n_cs = 1'b0; n_phase = sdsh_pkg::P_DESEL_DONE; emit_s = 1'b1;
        end
        if (emit_d) n_phase = sdsh_pkg::P_IDLE;

        item0 = '0; item1 = '0;
        item0.chip_select = n_cs; item0.fast_clock = n_fast; item0.card_kind = n_card;
        item1.chip_select = n_cs; item1.fast_clock = n_fast; item1.card_kind = n_card;
        item1.kind = sdsh_pkg::K_SEND; item1.byte_value = 8'hFF;
        npush = 2'd0;
        if (emit_r) begin
            item0.kind = sdsh_pkg::K_RDAT; item0.byte_value = rb; item0.last = rlast;
            npush = 2'd2;
        end else if (emit_d) begin
            item0.kind = sdsh_pkg::K_DONE; item0.status = dst; npush = 2'd1;
        end else if (emit_n) begin
            item0.kind = sdsh_pkg::K_NEED; npush = 2'd1;
        end else if (emit_s) begin
            item0.kind = sdsh_pkg::K_SEND; item0.byte_value = sb; npush = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdsh_pkg::P_IDLE; r_card <= '0; r_wty <= '0; r_noinit <= 1'b1;
            r_cs <= 1'b0; r_fast <= 1'b0; r_ms <= '0; r_rdy <= '0; r_poll <= '0;
            r_bi <= '0; r_left <= '0; r_addr <= '0; r_frame <= '0; r_ocr <= '0;
            r_parg <= '0; r_cret <= R_NONE; r_wret <= R_NONE; r_resp <= '0;
            r_rdyok <= 1'b0; r_apend <= 1'b0; r_multi <= 1'b0; r_pcmd <= '0;
            r_fst <= '0;
        end else begin
            r_phase <= n_phase; r_card <= n_card; r_wty <= n_wty; r_noinit <= n_noinit;
            r_cs <= n_cs; r_fast <= n_fast; r_ms <= n_ms; r_rdy <= n_rdy; r_poll <= n_poll;
            r_bi <= n_bi; r_left <= n_left; r_addr <= n_addr; r_frame <= n_frame;
            r_ocr <= n_ocr; r_parg <= n_parg; r_cret <= n_cret; r_wret <= n_wret;
            r_resp <= n_resp; r_rdyok <= n_rdyok; r_apend <= n_apend;
            r_multi <= n_multi; r_pcmd <= n_pcmd; r_fst <= n_fst;
        end
    end

    sdsh_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push_n(npush),
        .i_item0 (item0),
        .i_item1 (item1),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_item  (o_out.payload),
        .i_pop   (o_out.ready)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/sdsh_checker.sv =====
// sdsh_port_checks: port-level checks for the sd spi host sequencer
// depends on sdsh_pkg, bound to sd_spi_host_sequencer_top
`default_nettype none
module sdsh_port_checks (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire sdsh_pkg::t_out out_item
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");
    a_done_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_item.kind == sdsh_pkg::K_DONE |-> !out_item.chip_select)
        else $error("done with card selected");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_item.kind != sdsh_pkg::K_DONE |-> out_item.status == sdsh_pkg::ST_OK)
        else $error("status outside done");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_item.last |-> out_item.kind == sdsh_pkg::K_RDAT)
        else $error("last on non-read item");
endmodule

bind sd_spi_host_sequencer_top sdsh_port_checks u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .out_valid(o_out.valid),
    .out_ready(o_out.ready),
    .out_item (o_out.payload)
);
`default_nettype wire
